@@ rtl/frac_pkg.sv @@
// ----------------------------------------------------------------------------
// frac_pkg
// Shared widths, opcodes, word types and sequencer states for the fraction
// add, multiply and reduce unit.
// ----------------------------------------------------------------------------
package frac_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = OPERAND_WIDTH - 1;
    localparam int PROD_W        = 2 * MAG_W;
    localparam int DATA_W        = PROD_W + 1;
    localparam int CNT_W         = $clog2(DATA_W);
    localparam int RES_NUM_W     = 32;
    localparam int RES_DEN_W     = 30;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_ADD_RED = 2'd1;
    localparam logic [1:0] OP_MUL_RED = 2'd2;
    localparam logic [1:0] OP_CMP     = 2'd3;

    typedef struct packed {
        logic [1:0]                      opcode;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } t_frac_in;

    typedef struct packed {
        logic signed [RES_NUM_W-1:0] res_num;
        logic [RES_DEN_W-1:0]        res_den;
        logic                        res_empty;
        logic                        is_equal;
        logic                        is_not_equal;
    } t_frac_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_D,
        ST_LOAD,
        ST_GCD,
        ST_DIV_N,
        ST_DIV_D,
        ST_DONE
    } t_state;

endpackage

@@ rtl/fraction_add_mul_reduce.sv @@
// ----------------------------------------------------------------------------
// fraction_add_mul_reduce
// Adds or multiplies two fractions and reduces the result by the gcd (OP_ADD leaves the
// sum unreduced) or compares them, using one shared multiplier and one shared subtractor under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+-------------
//  input    | in        | start / busy       | t_frac_in
//  result   | out       | o_done (strobe)    | t_frac_out
//
//  Empty operands and compare go from accept straight to ST_DONE; unreduced adds and zero
//  sums pass ST_MUL_A, ST_MUL_B, ST_MUL_D and ST_LOAD first. Reduced results add a binary
//  gcd on the shared subtractor and then two restoring divisions, ST_DIV_N and ST_DIV_D.
//  busy stays high from accept through the o_done cycle; reset is synchronous.
//  The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module fraction_add_mul_reduce
    import frac_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_frac_in  i_item,
    output logic      busy,
    output logic      o_done,
    output t_frac_out o_result
);

    t_state r_state, n_state;

    logic [1:0]        r_opc;
    logic              r_ok;
    logic              r_eq;
    logic [MAG_W-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc, r_den;
    logic [DATA_W-1:0] r_x, r_y, r_qn, r_qd;
    logic [DATA_W-1:0] r_dvd, r_rem;
    logic [CNT_W-1:0]  r_cnt;

    logic [MAG_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic [DATA_W:0]   sub_a, sub_b, diff;
    logic [DATA_W:0]   div_sh;
    logic              div_bit;
    logic              cnt_last;
    logic              gcd_done;
    logic              in_ok;
    logic              in_eq;

    assign in_ok = !i_item.a_num[OPERAND_WIDTH-1] && !i_item.a_den[OPERAND_WIDTH-1]
                && (i_item.a_den != '0)
                && !i_item.b_num[OPERAND_WIDTH-1] && !i_item.b_den[OPERAND_WIDTH-1]
                && (i_item.b_den != '0);
    assign in_eq = (i_item.a_num == i_item.b_num) && (i_item.a_den == i_item.b_den);

    always_comb begin
        mul_a = r_an;
        mul_b = r_bd;
        case (r_state)
            ST_MUL_A: begin
                mul_a = r_an;
                mul_b = (r_opc == OP_MUL_RED) ? r_bn : r_bd;
            end
            ST_MUL_B: begin
                mul_a = r_bn;
                mul_b = r_ad;
            end
            ST_MUL_D: begin
                mul_a = r_ad;
                mul_b = r_bd;
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bd;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign div_sh = {r_rem, r_dvd[DATA_W-1]};

    always_comb begin
        if (r_state == ST_GCD) begin
            sub_a = {1'b0, r_x};
            sub_b = {1'b0, r_y};
        end else begin
            sub_a = div_sh;
            sub_b = {1'b0, r_x};
        end
    end

    assign diff     = sub_a - sub_b;
    assign div_bit  = !diff[DATA_W];
    assign cnt_last = (r_cnt == CNT_W'(DATA_W - 1));
    assign gcd_done = r_x[0] && r_y[0] && (diff == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (in_ok && i_item.opcode != OP_CMP) ? ST_MUL_A : ST_DONE;
                end
            end
            ST_MUL_A: n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_LOAD;
            ST_LOAD: begin
                n_state = (r_opc == OP_ADD || r_acc == '0) ? ST_DONE : ST_GCD;
            end
            ST_GCD: begin
                if (gcd_done) begin
                    n_state = ST_DIV_N;
                end
            end
            ST_DIV_N: begin
                if (cnt_last) begin
                    n_state = ST_DIV_D;
                end
            end
            ST_DIV_D: begin
                if (cnt_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_opc <= i_item.opcode;
                r_ok  <= in_ok;
                r_eq  <= in_eq;
                r_an  <= i_item.a_num[MAG_W-1:0];
                r_ad  <= i_item.a_den[MAG_W-1:0];
                r_bn  <= i_item.b_num[MAG_W-1:0];
                r_bd  <= i_item.b_den[MAG_W-1:0];
            end
            ST_MUL_A: begin
                r_prod <= prod;
            end
            ST_MUL_B: begin
                r_acc  <= DATA_W'(r_prod);
                r_prod <= prod;
            end
            ST_MUL_D: begin
                if (r_opc != OP_MUL_RED) begin
                    r_acc <= r_acc + DATA_W'(r_prod);
                end
                r_prod <= prod;
            end
            ST_LOAD: begin
                r_den <= DATA_W'(r_prod);
                r_x   <= r_acc;
                r_y   <= DATA_W'(r_prod);
                r_qn  <= r_acc;
                r_qd  <= DATA_W'(r_prod);
            end
            ST_GCD: begin
                if (!r_x[0] && !r_y[0]) begin
                    r_x  <= r_x >> 1;
                    r_y  <= r_y >> 1;
                    r_qn <= r_qn >> 1;
                    r_qd <= r_qd >> 1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (gcd_done) begin
                    r_x <= r_x;
                end else if (!diff[DATA_W]) begin
                    r_x <= diff[DATA_W:1];
                end else begin
                    r_x <= r_y;
                    r_y <= r_x;
                end
                r_dvd <= r_qn;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV_N, ST_DIV_D: begin
                if (cnt_last) begin
                    if (r_state == ST_DIV_N) begin
                        r_acc <= {r_dvd[DATA_W-2:0], div_bit};
                    end else begin
                        r_den <= {r_dvd[DATA_W-2:0], div_bit};
                    end
                    r_dvd <= r_qd;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else begin
                    r_dvd <= {r_dvd[DATA_W-2:0], div_bit};
                    r_rem <= div_bit ? diff[DATA_W-1:0] : div_sh[DATA_W-1:0];
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    always_comb begin
        busy   = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_result.res_empty    = !r_ok;
        o_result.is_equal     = r_ok && r_eq;
        o_result.is_not_equal = r_ok && !r_eq;
        if (r_opc == OP_CMP) begin
            o_result.res_num = '0;
            o_result.res_den = '0;
        end else if (!r_ok) begin
            o_result.res_num = '1;
            o_result.res_den = '0;
        end else begin
            o_result.res_num = RES_NUM_W'(r_acc);
            o_result.res_den = RES_DEN_W'(r_den);
        end
    end

endmodule
